// ----- src/wcf_pkg.sv -----
// ----------------------------------------------------------------------------
// wcf_pkg: shared types and constants for the wall contact force block
// Register indexes, contact codes, lane interface structs and the
// saturation helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package wcf_pkg;

    // word size of the force outputs, capped at 32 bits
    localparam int WORD_BITS = 32;
    localparam int SAT_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;

    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

    // 48 bit signed limits of the intermediates
    localparam logic signed [63:0] LIM48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48 = -LIM48 - 64'sd1;

    // register stages inside one force lane
    localparam int LANE_DEPTH = 8;

    localparam int PEN_W = 35;

    typedef enum logic [2:0] {
        CFG_BOX_WIDTH   = 3'd0,
        CFG_BOX_HEIGHT  = 3'd1,
        CFG_WALL_MARGIN = 3'd2,
        CFG_SPRING_K    = 3'd3,
        CFG_FRICTION_MU = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;

    localparam logic [1:0] VERT_NONE    = 2'd0;
    localparam logic [1:0] VERT_FLOOR   = 2'd1;
    localparam logic [1:0] VERT_CEILING = 2'd2;

    typedef struct packed {
        logic [1:0] side;
        logic [1:0] vert;
    } t_codes;

    // one wall pair as seen by a force lane
    typedef struct packed {
        logic                     valid;
        logic                     hit;
        logic                     slip_neg;   // slip uses -w*r
        logic                     tq_neg;     // torque term subtracted
        logic signed [PEN_W-1:0]  pen;
        logic signed [31:0]       vn;
        logic signed [31:0]       vt;
        logic signed [31:0]       w;
        logic [30:0]              r;
        logic [30:0]              eta;
    } t_lane_in;

    typedef struct packed {
        logic               valid;
        logic signed [47:0] n;
        logic signed [47:0] f;
        logic signed [48:0] t;
    } t_lane_out;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] c;
        begin
            if (v > LIM48) begin
                c = LIM48;
            end else if (v < MIN48) begin
                c = MIN48;
            end else begin
                c = v;
            end
            return c[47:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] c;
        begin
            if (v > OUT_MAX) begin
                c = OUT_MAX;
            end else if (v < OUT_MIN) begin
                c = OUT_MIN;
            end else begin
                c = v;
            end
            return c[31:0];
        end
    endfunction

endpackage

// ----- src/wcf_lane.sv -----
// ----------------------------------------------------------------------------
// wcf_lane: force pipeline for one wall pair
// Spring-dashpot normal force, Coulomb friction and torque term for one
// contact, eight register stages, one request per clock.
// ----------------------------------------------------------------------------
module wcf_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wcf_pkg::t_lane_in    i_lane,
    input  logic [30:0]          i_spring_k,
    input  logic [18:0]          i_fric_mu,
    output wcf_pkg::t_lane_out   o_lane
);

    // valid and control bits travel along every stage
    logic [wcf_pkg::LANE_DEPTH-1:0] r_vld;
    logic [wcf_pkg::LANE_DEPTH-1:0] r_hit;
    logic [wcf_pkg::LANE_DEPTH-1:0] r_tqn;

    // stage 1: partial products
    logic        [47:0] r1_pk_lo, n1_pk_lo;
    logic signed [49:0] r1_pk_hi, n1_pk_hi;
    logic signed [47:0] r1_dv, n1_dv;
    logic signed [47:0] r1_wr, n1_wr;
    logic signed [31:0] r1_vt;
    logic               r1_sneg;
    logic [30:0]        r1_r;

    // stage 2: spring force, slip sign
    logic signed [47:0] r2_ks, n2_ks;
    logic signed [47:0] r2_dv;
    logic               r2_szero, n2_szero;
    logic               r2_spos, n2_spos;
    logic [30:0]        r2_r;

    // stage 3: spring plus dashpot
    logic signed [48:0] r3_s, n3_s;
    logic               r3_szero, r3_spos;
    logic [30:0]        r3_r;

    // stage 4: normal force and its magnitude
    logic signed [47:0] r4_n, n4_n;
    logic        [46:0] r4_an, n4_an;
    logic               r4_szero, r4_spos;
    logic [30:0]        r4_r;

    // stage 5: friction partial products
    logic        [42:0] r5_pm_lo, n5_pm_lo;
    logic        [41:0] r5_pm_hi, n5_pm_hi;
    logic signed [47:0] r5_n;
    logic               r5_szero, r5_spos;
    logic [30:0]        r5_r;

    // stage 6: friction force
    logic signed [47:0] r6_f, n6_f;
    logic signed [47:0] r6_n;
    logic [30:0]        r6_r;

    // stage 7: torque partial products
    logic        [54:0] r7_pt_lo, n7_pt_lo;
    logic signed [55:0] r7_pt_hi, n7_pt_hi;
    logic signed [47:0] r7_f, r7_n;

    // stage 8: torque term, lane output
    logic signed [47:0] r8_n, n8_n;
    logic signed [47:0] r8_f, n8_f;
    logic signed [48:0] r8_t, n8_t;

    always_comb begin
        logic        [16:0] pl;
        logic signed [17:0] ph;
        logic signed [63:0] dv_full;
        logic signed [63:0] wr_full;
        pl       = i_lane.pen[16:0];
        ph       = i_lane.pen[wcf_pkg::PEN_W-1:17];
        n1_pk_lo = {31'd0, pl} * {17'd0, i_spring_k};
        n1_pk_hi = ph * $signed({1'b0, i_spring_k});
        dv_full  = i_lane.vn * $signed({1'b0, i_lane.eta});
        wr_full  = i_lane.w * $signed({1'b0, i_lane.r});
        // dropping low bits of a two's complement product rounds down
        n1_dv    = dv_full[63:16];
        n1_wr    = wr_full[63:16];
    end

    always_comb begin
        logic signed [66:0] ks_full;
        logic signed [50:0] ks_sh;
        logic signed [48:0] slip;
        ks_full  = ({{17{r1_pk_hi[49]}}, r1_pk_hi} <<< 17) + $signed({19'd0, r1_pk_lo});
        ks_sh    = ks_full[66:16];
        n2_ks    = wcf_pkg::sat48({{13{ks_sh[50]}}, ks_sh});
        if (r1_sneg) begin
            slip = {{17{r1_vt[31]}}, r1_vt} - {r1_wr[47], r1_wr};
        end else begin
            slip = {{17{r1_vt[31]}}, r1_vt} + {r1_wr[47], r1_wr};
        end
        n2_szero = (slip == 49'sd0);
        n2_spos  = !slip[48] && !n2_szero;
    end

    assign n3_s = {r2_ks[47], r2_ks} + {r2_dv[47], r2_dv};

    always_comb begin
        logic signed [49:0] neg_s;
        logic        [48:0] abs_s;
        neg_s = -{r3_s[48], r3_s};
        n4_n  = wcf_pkg::sat48({{14{neg_s[49]}}, neg_s});
        abs_s = r3_s[48] ? neg_s[48:0] : r3_s;
        // |n| is the magnitude of the sum clamped to the positive limit
        if (abs_s > 49'(wcf_pkg::LIM48)) begin
            n4_an = wcf_pkg::LIM48[46:0];
        end else begin
            n4_an = abs_s[46:0];
        end
    end

    assign n5_pm_lo = {19'd0, r4_an[23:0]} * {24'd0, i_fric_mu};
    assign n5_pm_hi = {19'd0, r4_an[46:24]} * {23'd0, i_fric_mu};

    always_comb begin
        logic [65:0] m_full;
        logic [49:0] m_sh;
        logic signed [47:0] m;
        m_full = {r5_pm_hi, 24'd0} + {23'd0, r5_pm_lo};
        m_sh   = m_full[65:16];
        if (m_sh > 50'(wcf_pkg::LIM48)) begin
            m = wcf_pkg::LIM48[47:0];
        end else begin
            m = {1'b0, m_sh[46:0]};
        end
        // friction opposes the slip, none when the contact point sticks
        if (r5_szero) begin
            n6_f = '0;
        end else if (r5_spos) begin
            n6_f = -m;
        end else begin
            n6_f = m;
        end
    end

    assign n7_pt_lo = {31'd0, r6_f[23:0]} * {24'd0, r6_r};
    assign n7_pt_hi = $signed(r6_f[47:24]) * $signed({1'b0, r6_r});

    always_comb begin
        logic signed [78:0] t_full;
        logic signed [62:0] t_sh;
        logic signed [47:0] tm;
        t_full = ({{23{r7_pt_hi[55]}}, r7_pt_hi} <<< 24) + $signed({24'd0, r7_pt_lo});
        t_sh   = t_full[78:16];
        tm     = wcf_pkg::sat48({t_sh[62], t_sh});
        if (!r_hit[6]) begin
            n8_n = '0;
            n8_f = '0;
            n8_t = '0;
        end else begin
            n8_n = r7_n;
            n8_f = r7_f;
            n8_t = r_tqn[6] ? -{tm[47], tm} : {tm[47], tm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[wcf_pkg::LANE_DEPTH-2:0], i_lane.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit    <= {r_hit[wcf_pkg::LANE_DEPTH-2:0], i_lane.hit};
        r_tqn    <= {r_tqn[wcf_pkg::LANE_DEPTH-2:0], i_lane.tq_neg};

        r1_pk_lo <= n1_pk_lo;
        r1_pk_hi <= n1_pk_hi;
        r1_dv    <= n1_dv;
        r1_wr    <= n1_wr;
        r1_vt    <= i_lane.vt;
        r1_sneg  <= i_lane.slip_neg;
        r1_r     <= i_lane.r;

        r2_ks    <= n2_ks;
        r2_dv    <= r1_dv;
        r2_szero <= n2_szero;
        r2_spos  <= n2_spos;
        r2_r     <= r1_r;

        r3_s     <= n3_s;
        r3_szero <= r2_szero;
        r3_spos  <= r2_spos;
        r3_r     <= r2_r;

        r4_n     <= n4_n;
        r4_an    <= n4_an;
        r4_szero <= r3_szero;
        r4_spos  <= r3_spos;
        r4_r     <= r3_r;

        r5_pm_lo <= n5_pm_lo;
        r5_pm_hi <= n5_pm_hi;
        r5_n     <= r4_n;
        r5_szero <= r4_szero;
        r5_spos  <= r4_spos;
        r5_r     <= r4_r;

        r6_f     <= n6_f;
        r6_n     <= r5_n;
        r6_r     <= r5_r;

        r7_pt_lo <= n7_pt_lo;
        r7_pt_hi <= n7_pt_hi;
        r7_f     <= r6_f;
        r7_n     <= r6_n;

        r8_n     <= n8_n;
        r8_f     <= n8_f;
        r8_t     <= n8_t;
    end

    assign o_lane.valid = r_vld[wcf_pkg::LANE_DEPTH-1];
    assign o_lane.n     = r8_n;
    assign o_lane.f     = r8_f;
    assign o_lane.t     = r8_t;

endmodule

// ----- src/wall_contact_force_top.sv -----
// ----------------------------------------------------------------------------
// wall_contact_force_top: box wall contact forces for one disc particle
// Tests the particle against the side walls and the floor or ceiling and
// returns spring-dashpot, friction and torque increments with contact codes.
// ----------------------------------------------------------------------------
// One request is taken on every clock at which start is high; busy never
// rises, so requests may be issued back to back without gaps. Each request
// gives exactly one result, shown for one cycle with o_valid high, in
// request order. On its way it passes the wall test stage, the eight stages
// of the force lane (normal force, friction and torque are three dependent
// products) and the output sum stage. The receiver cannot hold results off
// and must take every strobe. Configuration writes are always ready and
// must only be made while no request is in flight.
module wall_contact_force_top (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_spin,
    input  logic [30:0]        i_radius,
    input  logic [30:0]        i_damping,
    input  logic signed [31:0] i_floor_offset,
    input  logic signed [31:0] i_side_offset,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,

    output logic               o_valid,
    output logic signed [31:0] o_force_x_delta,
    output logic signed [31:0] o_force_y_delta,
    output logic signed [31:0] o_torque_delta,
    output logic [1:0]         o_side_contact,
    output logic [1:0]         o_vertical_contact
);

    localparam int PW = wcf_pkg::PEN_W;

    logic [30:0] r_box_width;
    logic [30:0] r_box_height;
    logic [30:0] r_wall_margin;
    logic [30:0] r_spring_k;
    logic [18:0] r_fric_mu;

    wcf_pkg::t_lane_in  r_side_in, n_side_in;
    wcf_pkg::t_lane_in  r_vert_in, n_vert_in;
    wcf_pkg::t_codes    r_codes_a, n_codes_a;
    wcf_pkg::t_codes    r_code_pipe [wcf_pkg::LANE_DEPTH];
    wcf_pkg::t_lane_out side_out;
    wcf_pkg::t_lane_out vert_out;

    logic               r_valid;
    logic signed [31:0] r_fx, n_fx;
    logic signed [31:0] r_fy, n_fy;
    logic signed [31:0] r_tq, n_tq;
    logic [1:0]         r_side, r_vert;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width   <= 31'd6553600;
            r_box_height  <= 31'd6553600;
            r_wall_margin <= 31'd65536;
            r_spring_k    <= 31'd65536;
            r_fric_mu     <= 19'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (wcf_pkg::t_cfg_idx'(i_cfg_index))
                wcf_pkg::CFG_BOX_WIDTH:   r_box_width   <= i_cfg_data[30:0];
                wcf_pkg::CFG_BOX_HEIGHT:  r_box_height  <= i_cfg_data[30:0];
                wcf_pkg::CFG_WALL_MARGIN: r_wall_margin <= i_cfg_data[30:0];
                wcf_pkg::CFG_SPRING_K:    r_spring_k    <= i_cfg_data[30:0];
                wcf_pkg::CFG_FRICTION_MU: r_fric_mu     <= i_cfg_data[18:0];
                default: begin
                end
            endcase
        end
    end

    // wall tests: penetration depths, sign decides contact
    always_comb begin
        logic signed [PW-1:0] x, y, r, d, s, b, bw, bh;
        logic signed [PW-1:0] pen_r, pen_l, pen_f, pen_c;
        logic                 hit_r, hit_l, hit_f, hit_c;
        x  = {{(PW-32){i_pos_x[31]}}, i_pos_x};
        y  = {{(PW-32){i_pos_y[31]}}, i_pos_y};
        s  = {{(PW-32){i_side_offset[31]}}, i_side_offset};
        b  = {{(PW-32){i_floor_offset[31]}}, i_floor_offset};
        r  = {{(PW-31){1'b0}}, i_radius};
        d  = {{(PW-31){1'b0}}, r_wall_margin};
        bw = {{(PW-31){1'b0}}, r_box_width};
        bh = {{(PW-31){1'b0}}, r_box_height};

        pen_r = x + r + d + s - bw;
        pen_l = x - r - d - s;
        pen_f = y + r + d + b - bh;
        pen_c = y - r - d;

        hit_r = !pen_r[PW-1] && (pen_r != '0);
        hit_l = !hit_r && pen_l[PW-1];
        hit_f = !pen_f[PW-1] && (pen_f != '0);
        hit_c = !hit_f && pen_c[PW-1];

        if (hit_r) begin
            n_codes_a.side = wcf_pkg::SIDE_RIGHT;
        end else if (hit_l) begin
            n_codes_a.side = wcf_pkg::SIDE_LEFT;
        end else begin
            n_codes_a.side = wcf_pkg::SIDE_NONE;
        end
        if (hit_f) begin
            n_codes_a.vert = wcf_pkg::VERT_FLOOR;
        end else if (hit_c) begin
            n_codes_a.vert = wcf_pkg::VERT_CEILING;
        end else begin
            n_codes_a.vert = wcf_pkg::VERT_NONE;
        end

        n_side_in.valid    = start && !busy;
        n_side_in.hit      = hit_r || hit_l;
        n_side_in.slip_neg = !hit_r;
        n_side_in.tq_neg   = !hit_r;
        n_side_in.pen      = hit_r ? pen_r : pen_l;
        n_side_in.vn       = i_vel_x;
        n_side_in.vt       = i_vel_y;
        n_side_in.w        = i_spin;
        n_side_in.r        = i_radius;
        n_side_in.eta      = i_damping;

        n_vert_in.valid    = start && !busy;
        n_vert_in.hit      = hit_f || hit_c;
        n_vert_in.slip_neg = hit_f;
        n_vert_in.tq_neg   = hit_f;
        n_vert_in.pen      = hit_f ? pen_f : pen_c;
        n_vert_in.vn       = i_vel_y;
        n_vert_in.vt       = i_vel_x;
        n_vert_in.w        = i_spin;
        n_vert_in.r        = i_radius;
        n_vert_in.eta      = i_damping;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_in.valid <= 1'b0;
            r_vert_in.valid <= 1'b0;
        end else begin
            r_side_in.valid <= n_side_in.valid;
            r_vert_in.valid <= n_vert_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_in.hit      <= n_side_in.hit;
        r_side_in.slip_neg <= n_side_in.slip_neg;
        r_side_in.tq_neg   <= n_side_in.tq_neg;
        r_side_in.pen      <= n_side_in.pen;
        r_side_in.vn       <= n_side_in.vn;
        r_side_in.vt       <= n_side_in.vt;
        r_side_in.w        <= n_side_in.w;
        r_side_in.r        <= n_side_in.r;
        r_side_in.eta      <= n_side_in.eta;
        r_vert_in.hit      <= n_vert_in.hit;
        r_vert_in.slip_neg <= n_vert_in.slip_neg;
        r_vert_in.tq_neg   <= n_vert_in.tq_neg;
        r_vert_in.pen      <= n_vert_in.pen;
        r_vert_in.vn       <= n_vert_in.vn;
        r_vert_in.vt       <= n_vert_in.vt;
        r_vert_in.w        <= n_vert_in.w;
        r_vert_in.r        <= n_vert_in.r;
        r_vert_in.eta      <= n_vert_in.eta;
        r_codes_a          <= n_codes_a;
        // contact codes ride alongside the lanes
        r_code_pipe[0]     <= r_codes_a;
        for (int i = 1; i < wcf_pkg::LANE_DEPTH; i++) begin
            r_code_pipe[i] <= r_code_pipe[i-1];
        end
    end

    wcf_lane u_side_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane     (r_side_in),
        .i_spring_k (r_spring_k),
        .i_fric_mu  (r_fric_mu),
        .o_lane     (side_out)
    );

    wcf_lane u_vert_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane     (r_vert_in),
        .i_spring_k (r_spring_k),
        .i_fric_mu  (r_fric_mu),
        .o_lane     (vert_out)
    );

    // side normal on x, floor/ceiling friction on x, and the reverse on y
    always_comb begin
        logic signed [49:0] fx, fy, tq;
        fx   = {{2{side_out.n[47]}}, side_out.n} + {{2{vert_out.f[47]}}, vert_out.f};
        fy   = {{2{side_out.f[47]}}, side_out.f} + {{2{vert_out.n[47]}}, vert_out.n};
        tq   = {side_out.t[48], side_out.t} + {vert_out.t[48], vert_out.t};
        n_fx = wcf_pkg::sat_out({{14{fx[49]}}, fx});
        n_fy = wcf_pkg::sat_out({{14{fy[49]}}, fy});
        n_tq = wcf_pkg::sat_out({{14{tq[49]}}, tq});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= side_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx   <= n_fx;
        r_fy   <= n_fy;
        r_tq   <= n_tq;
        r_side <= r_code_pipe[wcf_pkg::LANE_DEPTH-1].side;
        r_vert <= r_code_pipe[wcf_pkg::LANE_DEPTH-1].vert;
    end

    assign o_valid            = r_valid;
    assign o_force_x_delta    = r_fx;
    assign o_force_y_delta    = r_fy;
    assign o_torque_delta     = r_tq;
    assign o_side_contact     = r_side;
    assign o_vertical_contact = r_vert;

    // every accepted request comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##10 o_valid)
        else $error("request did not produce a result after the pipeline latency");

    // no result without a request taken at the matching edge
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 10))
        else $error("result strobe without a matching request");

    // without any contact there is no force and no torque
    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side_contact == wcf_pkg::SIDE_NONE
                 && o_vertical_contact == wcf_pkg::VERT_NONE)
        |-> (o_force_x_delta == 32'sd0 && o_force_y_delta == 32'sd0
             && o_torque_delta == 32'sd0))
        else $error("force reported without wall contact");

    // both lanes run in lockstep
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        side_out.valid == vert_out.valid)
        else $error("side and vertical lanes out of step");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for wall_contact_force_top
// Drives particle requests and box register writes, predicts each contact
// result in fixed point and compares it field by field with the block output.
// ----------------------------------------------------------------------------
module tb;
    import wcf_pkg::*;

    localparam longint Q      = 65536;
    localparam longint MAXW   = 64'sd2147483647;
    localparam longint MINW   = -64'sd2147483648;
    localparam longint MAX31  = 64'sd2147483647;
    localparam longint MU_MAX = 262144;

    localparam longint     HI48   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     LO48   = -HI48 - 1;
    localparam logic [63:0] HI48_U = 64'h0000_7FFF_FFFF_FFFF;

    localparam int PIPE_LATENCY = 10;
    localparam int PHASE_ITEMS  = 150;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
        logic [30:0]        radius;
        logic [30:0]        damping;
        logic signed [31:0] floor_offset;
        logic signed [31:0] side_offset;
    } particle_t;

    typedef struct {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] torque;
        logic [1:0]         side;
        logic [1:0]         vert;
    } contact_t;

    class wall_force_scoreboard;
        longint   box_w, box_h, margin, stiff, mu;
        contact_t forces_due[$];
        int       mismatches, requests, checked;
        int       side_hits[4], vert_hits[4];

        function new();
            box_w  = 6553600;
            box_h  = 6553600;
            margin = 65536;
            stiff  = 65536;
            mu     = 32768;
        endfunction

        function void set_register(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_BOX_WIDTH:   box_w  = longint'(data[30:0]);
                CFG_BOX_HEIGHT:  box_h  = longint'(data[30:0]);
                CFG_WALL_MARGIN: margin = longint'(data[30:0]);
                CFG_SPRING_K:    stiff  = longint'(data[30:0]);
                CFG_FRICTION_MU: mu     = longint'(data[18:0]);
                default: ;
            endcase
        endfunction

        static function longint clamp48(longint v);
            if (v > HI48) return HI48;
            if (v < LO48) return LO48;
            return v;
        endfunction

        // a*b/2^16 rounded toward minus infinity, b non-negative
        static function longint mul_floor(longint a, longint b);
            logic [63:0] ma, ub, lo, mag;
            ub  = b;
            ma  = (a < 0) ? -a : a;
            lo  = {48'd0, ma[15:0]} * ub;
            mag = (ma >> 16) * ub + (lo >> 16);
            if (a < 0) begin
                if (lo[15:0] != 16'd0) mag = mag + 64'd1;
                if (mag > HI48_U + 64'd1) return LO48;
                return -longint'(mag);
            end
            if (mag > HI48_U) return HI48;
            return longint'(mag);
        endfunction

        static function longint mul_signed(longint a, longint b);
            if (b < 0) return clamp48(-mul_floor(a, -b));
            return mul_floor(a, b);
        endfunction

        static function logic signed [31:0] to_word(longint v);
            if (v > MAXW) v = MAXW;
            if (v < MINW) v = MINW;
            return 32'(v);
        endfunction

        function longint normal_force(longint pen, longint eta, longint vn);
            longint ks, dv;
            ks = mul_floor(clamp48(pen), stiff);
            dv = mul_signed(vn, eta);
            return clamp48(-ks - dv);
        endfunction

        function longint friction_force(longint n, longint slip);
            longint m;
            if (slip == 0) return 0;
            m = mul_floor((n < 0) ? clamp48(-n) : n, mu);
            return (slip > 0) ? -m : m;
        endfunction

        function contact_t predict_wall_force(particle_t p);
            contact_t c;
            longint   x, y, vx, vy, w, r, eta, b, s, wr, fx, fy, tq, n, f;
            x   = p.pos_x;
            y   = p.pos_y;
            vx  = p.vel_x;
            vy  = p.vel_y;
            w   = p.spin;
            r   = longint'(p.radius);
            eta = longint'(p.damping);
            b   = p.floor_offset;
            s   = p.side_offset;
            wr  = mul_signed(w, r);
            fx  = 0;
            fy  = 0;
            tq  = 0;
            c.side = SIDE_NONE;
            c.vert = VERT_NONE;
            if (x > box_w - margin - r - s) begin
                c.side = SIDE_RIGHT;
                n  = normal_force(x + r - (box_w - margin - s), eta, vx);
                f  = friction_force(n, vy + wr);
                fx += n;
                fy += f;
                tq += mul_floor(f, r);
            end else if (x < margin + r + s) begin
                c.side = SIDE_LEFT;
                n  = normal_force(x - r - margin - s, eta, vx);
                f  = friction_force(n, vy - wr);
                fx += n;
                fy += f;
                tq -= mul_floor(f, r);
            end
            if (y > box_h - margin - r - b) begin
                c.vert = VERT_FLOOR;
                n  = normal_force(y + r - (box_h - margin - b), eta, vy);
                f  = friction_force(n, vx - wr);
                fy += n;
                fx += f;
                tq -= mul_floor(f, r);
            end else if (y < margin + r) begin
                c.vert = VERT_CEILING;
                n  = normal_force(y - r - margin, eta, vy);
                f  = friction_force(n, vx + wr);
                fy += n;
                fx += f;
                tq += mul_floor(f, r);
            end
            c.force_x = to_word(fx);
            c.force_y = to_word(fy);
            c.torque  = to_word(tq);
            return c;
        endfunction

        function void note_request(particle_t p);
            forces_due.push_back(predict_wall_force(p));
            requests++;
        endfunction

        function void check_result(contact_t got);
            contact_t want;
            if (forces_due.size() == 0) begin
                $error("result with no request pending");
                mismatches++;
                return;
            end
            want = forces_due.pop_front();
            checked++;
            side_hits[want.side]++;
            vert_hits[want.vert]++;
            if (got.force_x !== want.force_x) begin
                $error("force_x_delta: expected %0d, got %0d", want.force_x, got.force_x);
                mismatches++;
            end
            if (got.force_y !== want.force_y) begin
                $error("force_y_delta: expected %0d, got %0d", want.force_y, got.force_y);
                mismatches++;
            end
            if (got.torque !== want.torque) begin
                $error("torque_delta: expected %0d, got %0d", want.torque, got.torque);
                mismatches++;
            end
            if (got.side !== want.side) begin
                $error("side_contact: expected %0d, got %0d", want.side, got.side);
                mismatches++;
            end
            if (got.vert !== want.vert) begin
                $error("vertical_contact: expected %0d, got %0d", want.vert, got.vert);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_pos_x, i_pos_y, i_vel_x, i_vel_y, i_spin;
    logic [30:0]        i_radius, i_damping;
    logic signed [31:0] i_floor_offset, i_side_offset;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic signed [31:0] o_force_x_delta, o_force_y_delta, o_torque_delta;
    logic [1:0]         o_side_contact, o_vertical_contact;

    wall_force_scoreboard sb;
    int                   settings_loaded;

    wall_contact_force_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_vel_x            (i_vel_x),
        .i_vel_y            (i_vel_y),
        .i_spin             (i_spin),
        .i_radius           (i_radius),
        .i_damping          (i_damping),
        .i_floor_offset     (i_floor_offset),
        .i_side_offset      (i_side_offset),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_force_x_delta    (o_force_x_delta),
        .o_force_y_delta    (o_force_y_delta),
        .o_torque_delta     (o_torque_delta),
        .o_side_contact     (o_side_contact),
        .o_vertical_contact (o_vertical_contact)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        contact_t got;
        if (i_rst_n && o_valid) begin
            got.force_x = o_force_x_delta;
            got.force_y = o_force_y_delta;
            got.torque  = o_torque_delta;
            got.side    = o_side_contact;
            got.vert    = o_vertical_contact;
            sb.check_result(got);
        end
    end

    function automatic longint small_signed(int span);
        return longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    function automatic particle_t make_particle(longint x, longint y, longint vx, longint vy,
                                                longint w, longint r, longint e,
                                                longint b, longint s);
        particle_t p;
        p.pos_x        = 32'(x);
        p.pos_y        = 32'(y);
        p.vel_x        = 32'(vx);
        p.vel_y        = 32'(vy);
        p.spin         = 32'(w);
        p.radius       = 31'(r);
        p.damping      = 31'(e);
        p.floor_offset = 32'(b);
        p.side_offset  = 32'(s);
        return p;
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        int        kind;
        longint    r, s, b, tol, x, y, wr;
        kind           = $urandom_range(0, 9);
        p.pos_x        = $urandom;
        p.pos_y        = $urandom;
        p.vel_x        = $urandom;
        p.vel_y        = $urandom;
        p.spin         = $urandom;
        p.radius       = 31'($urandom);
        p.damping      = 31'($urandom);
        p.floor_offset = $urandom;
        p.side_offset  = $urandom;
        if (kind < 2) return p;
        // place the disc near a wall of the current box, or in the middle
        r   = (kind == 8) ? longint'($urandom_range(0, 32'h7FFF_FFFF))
                          : longint'($urandom_range(0, 8 << 16));
        s   = small_signed(4 << 16);
        b   = small_signed(4 << 16);
        tol = ($urandom_range(0, 3) == 0) ? 2 : (1 << 16);
        case ($urandom_range(0, 2))
            0:       x = sb.box_w / 2 + small_signed(1 << 16);
            1:       x = sb.box_w - sb.margin - r - s + small_signed(int'(tol));
            default: x = sb.margin + r + s + small_signed(int'(tol));
        endcase
        case ($urandom_range(0, 2))
            0:       y = sb.box_h / 2 + small_signed(1 << 16);
            1:       y = sb.box_h - sb.margin - r - b + small_signed(int'(tol));
            default: y = sb.margin + r + small_signed(int'(tol));
        endcase
        p.pos_x        = 32'(x);
        p.pos_y        = 32'(y);
        p.vel_x        = 32'(small_signed(1 << 20));
        p.vel_y        = 32'(small_signed(1 << 20));
        p.spin         = 32'(small_signed(1 << 18));
        p.radius       = 31'(r);
        p.damping      = 31'($urandom_range(0, 1 << 18));
        p.floor_offset = 32'(b);
        p.side_offset  = 32'(s);
        if (kind == 9) begin
            // contact point with no slip
            wr = wall_force_scoreboard::mul_signed(longint'(p.spin), r);
            case ($urandom_range(0, 2))
                0: begin
                    p.spin  = '0;
                    p.vel_x = '0;
                    p.vel_y = '0;
                end
                1:       p.vel_y = 32'(-wr);
                default: p.vel_x = 32'(wr);
            endcase
        end
        return p;
    endfunction

    task automatic issue_particle(particle_t p);
        @(negedge i_clk);
        start          <= 1'b1;
        i_pos_x        <= p.pos_x;
        i_pos_y        <= p.pos_y;
        i_vel_x        <= p.vel_x;
        i_vel_y        <= p.vel_y;
        i_spin         <= p.spin;
        i_radius       <= p.radius;
        i_damping      <= p.damping;
        i_floor_offset <= p.floor_offset;
        i_side_offset  <= p.side_offset;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(p);
    endtask

    task automatic hold_off(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_forces_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.forces_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_box_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // 0 typical box, 1 all zero, 2 all max, 3 random, 4 typical box with stiff walls
    task automatic load_box_setting(int mode);
        longint w, h, d, k, m;
        case (mode)
            1: begin
                w = 0; h = 0; d = 0; k = 0; m = 0;
            end
            2: begin
                w = MAX31; h = MAX31; d = MAX31; k = MAX31; m = MU_MAX;
            end
            3: begin
                w = $urandom_range(0, 32'h7FFF_FFFF);
                h = $urandom_range(0, 32'h7FFF_FFFF);
                d = $urandom_range(0, 32'h7FFF_FFFF);
                k = $urandom_range(0, 32'h7FFF_FFFF);
                m = $urandom_range(0, MU_MAX);
            end
            default: begin
                w = $urandom_range(16 << 16, 400 << 16);
                h = $urandom_range(16 << 16, 400 << 16);
                d = $urandom_range(0, 4 << 16);
                k = (mode == 4) ? MAX31 : longint'($urandom_range(0, 64 << 16));
                m = (mode == 4) ? MU_MAX : longint'($urandom_range(0, MU_MAX));
            end
        endcase
        wait_forces_drained();
        // unused upper data bits carry noise
        write_box_reg(CFG_BOX_WIDTH,   {1'($urandom), 31'(w)});
        write_box_reg(CFG_BOX_HEIGHT,  {1'($urandom), 31'(h)});
        write_box_reg(CFG_WALL_MARGIN, {1'($urandom), 31'(d)});
        write_box_reg(CFG_SPRING_K,    {1'($urandom), 31'(k)});
        write_box_reg(CFG_FRICTION_MU, {13'($urandom), 19'(m)});
        settings_loaded++;
    endtask

    initial begin
        int phase_modes[8];
        int gap;
        phase_modes     = '{0, 2, 1, 3, 4, 0, 3, 0};
        sb              = new();
        settings_loaded = 1;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_pos_x         = '0;
        i_pos_y         = '0;
        i_vel_x         = '0;
        i_vel_y         = '0;
        i_spin          = '0;
        i_radius        = '0;
        i_damping       = '0;
        i_floor_offset  = '0;
        i_side_offset   = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_BOX_WIDTH;
        i_cfg_data      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests on the reset box
        issue_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        issue_particle(make_particle(50*Q, 50*Q, 3*Q, -2*Q, Q, Q, Q/2, 0, 0));
        issue_particle(make_particle(98*Q + Q/4, 50*Q, 2*Q, Q, Q, Q, Q/2, 0, 0));
        issue_particle(make_particle(2*Q - Q/4, 50*Q, -Q, -3*Q, Q, Q, Q/2, 0, 0));
        issue_particle(make_particle(50*Q, 98*Q + Q/8, -Q, 2*Q, 0, Q, Q, 0, 0));
        issue_particle(make_particle(50*Q, 2*Q - Q/3, Q, -Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(98*Q + Q/2, 98*Q + Q/2, Q, Q, -Q, Q, Q/4, 0, 0));
        issue_particle(make_particle(Q, Q, -2*Q, -Q, 2*Q, Q, Q/4, 0, 0));
        issue_particle(make_particle(98*Q + Q/2, 50*Q, Q, 0, 0, Q, Q, 0, 0));
        // exactly on each wall, and just past the side walls and the floor
        issue_particle(make_particle(98*Q, 50*Q, Q, Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(98*Q + 1, 50*Q, Q, Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(2*Q, 50*Q, Q, Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(2*Q - 1, 50*Q, Q, Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(50*Q, 98*Q, Q, Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(50*Q, 95*Q + 1, Q, Q, Q, Q, Q, 3*Q, 0));
        issue_particle(make_particle(50*Q, 2*Q, Q, Q, Q, Q, Q, 0, 0));
        issue_particle(make_particle(104*Q, 50*Q, Q, -Q, Q, Q, Q, 0, -5*Q));
        issue_particle(make_particle(6*Q, 50*Q, -Q, Q, -Q, Q, Q, 0, 5*Q));
        issue_particle(make_particle(MAXW, MAXW, MAXW, MAXW, MAXW, MAX31, MAX31, MAXW, MAXW));
        issue_particle(make_particle(MINW, MINW, MINW, MINW, MINW, MAX31, MAX31, MINW, MINW));
        issue_particle(make_particle(99*Q, 99*Q, -Q, Q, -5*Q, 0, 0, 0, 0));

        // stiffest spring and largest friction drive the sums into saturation
        wait_forces_drained();
        write_box_reg(CFG_SPRING_K, 32'(MAX31));
        write_box_reg(CFG_FRICTION_MU, 32'(MU_MAX));
        settings_loaded++;
        issue_particle(make_particle(MAXW, 50*Q, MAXW, MINW, MAXW, 2*Q, MAX31, 0, 0));
        issue_particle(make_particle(MINW, MAXW, MINW, MAXW, MINW, 2*Q, MAX31, MINW, 0));
        issue_particle(make_particle(50*Q, MINW, 0, MINW, 0, MAX31, MAX31, 0, 0));

        for (int ph = 0; ph < 8; ph++) begin
            load_box_setting(phase_modes[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                issue_particle(random_particle());
                // back-to-back stretch at the start of each phase
                gap = (i < 30) ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 99) == 0) begin
                    wait_forces_drained();
                end else if (gap > 0) begin
                    hold_off(gap);
                end
            end
        end

        wait_forces_drained();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        $display("tb: %0d requests, %0d results over %0d box settings",
                 sb.requests, sb.checked, settings_loaded);
        $display("tb: right/left %0d/%0d, floor/ceiling %0d/%0d, %0d mismatches",
                 sb.side_hits[SIDE_RIGHT], sb.side_hits[SIDE_LEFT],
                 sb.vert_hits[VERT_FLOOR], sb.vert_hits[VERT_CEILING], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
